// ----- sv/ipv6p_pkg.sv -----
// Shared types and constants for the IPv6 text address parser.
`timescale 1ns / 1ps

package ipv6p_pkg;

  localparam int unsigned GROUPS     = 8;
  localparam int unsigned GROUP_W    = 16;
  localparam int unsigned ADDR_W     = GROUPS * GROUP_W;
  localparam int unsigned HALF_W     = ADDR_W / 2;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DIG_W      = 3;

  localparam logic [CNT_W-1:0] GROUPS_FULL = 4'd8;
  localparam logic [DIG_W-1:0] MAX_DIGITS  = 3'd4;

  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_F   = 8'h66;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [3:0] LETTER_OFFS = 4'd9;

  // Class of one address character.
  typedef struct packed {
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // Finished address handed to the output stage.
  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

// ----- sv/ipv6_text_address_parser.sv -----
// Top level of the IPv6 text address parser.
`timescale 1ns / 1ps

// Feed the characters of one textual IPv6 address (no brackets), one item
// per character, with tlast on the final character. Hex digits (up to four
// per group) build 16-bit groups separated by ':'; the first "::" marks the
// zero-filled gap, later ones act as single separators; text past eight
// groups is ignored. On the final character the block emits two items: the
// high 64 bits (group 0 on top), then the low 64 bits with tlast set, both
// carrying parse_ok. A fifth digit in a group or any non-hex, non-colon
// character clears parse_ok and forces the address to zero. Dotted IPv4
// tails are not decoded. Throughput is one character per cycle; each input
// item passes one input register and one parse step. A final character
// waits in the input register until the two-word output buffer is free.
// With a consumer that takes every output item at once this costs nothing
// for back-to-back addresses of two or more characters; a one-character
// address waits until both output items of the one before have gone.
// After reset the block is ready at once.

module ipv6_text_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] addr_word, [64] parse_ok, [71:65] zero
  output logic        out_tlast   // word_last
);

  // Input register: holds one character until the parse step takes it.
  logic        in_v_r, in_v_nxt;
  logic [7:0]  in_char_r;
  logic        in_last_r;

  logic                   step;
  logic                   buf_can_load;
  ipv6p_pkg::char_class_t cls;
  ipv6p_pkg::result_t     res;

  // Advance a plain character at once; hold a final character until the
  // output buffer can take the finished address.
  assign step      = in_v_r && (!in_last_r || buf_can_load);
  assign in_tready = !in_v_r || step;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt = 1'b1;
    end else if (step) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  ipv6p_char_class u_class (
    .char_code (in_char_r),
    .cls       (cls)
  );

  ipv6p_parse_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .last  (in_last_r),
    .cls   (cls),
    .res   (res)
  );

  // Load the output buffer only on the step of a final character.
  ipv6p_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && in_last_r),
    .res        (res),
    .can_load   (buf_can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_hold_waiting_char: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !step |=> in_v_r && $stable(in_char_r) && $stable(in_last_r))
    else $error("waiting character lost or changed");

  a_final_waits_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && in_last_r && !buf_can_load |-> !in_tready)
    else $error("input taken while final character is blocked");

  a_plain_char_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !in_last_r |-> step && in_tready)
    else $error("plain character stalled");

endmodule

// ----- sv/ipv6p_char_class.sv -----
// Character classifier: colon detect and hex digit decode.
`timescale 1ns / 1ps

module ipv6p_char_class (
  input  logic [7:0]                char_code,
  output ipv6p_pkg::char_class_t    cls
);

  logic [7:0] low_bits;

  assign low_bits = char_code & ipv6p_pkg::NIBBLE_MASK;

  always_comb begin
    cls.is_colon = (char_code == ipv6p_pkg::CHAR_COLON);
    cls.is_hex   = 1'b0;
    cls.nibble   = 4'd0;
    priority if (char_code >= ipv6p_pkg::CHAR_0 && char_code <= ipv6p_pkg::CHAR_9) begin
      cls.is_hex = 1'b1;
      cls.nibble = low_bits[3:0];
    end else if (char_code >= ipv6p_pkg::CHAR_LO_A && char_code <= ipv6p_pkg::CHAR_LO_F) begin
      cls.is_hex = 1'b1;
      cls.nibble = low_bits[3:0] + ipv6p_pkg::LETTER_OFFS;
    end else if (char_code >= ipv6p_pkg::CHAR_UP_A && char_code <= ipv6p_pkg::CHAR_UP_F) begin
      cls.is_hex = 1'b1;
      cls.nibble = low_bits[3:0] + ipv6p_pkg::LETTER_OFFS;
    end else begin
      cls.is_hex = 1'b0;
    end
  end

endmodule

// ----- sv/ipv6p_parse_core.sv -----
// Parse state: digit accumulation, group commit and split expansion.
`timescale 1ns / 1ps

module ipv6p_parse_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        last,
  input  ipv6p_pkg::char_class_t      cls,
  output ipv6p_pkg::result_t          res
);

  // Groups before the split sit at fixed slots; groups after it shift in
  // from the bottom so they end up right-aligned at the address end.
  typedef struct packed {
    logic [ipv6p_pkg::GROUPS-1:0][ipv6p_pkg::GROUP_W-1:0] head;
    logic [ipv6p_pkg::ADDR_W-1:0]                         tail;
    logic [ipv6p_pkg::CNT_W-1:0]                          gc;
    logic                                                 split;
    logic [ipv6p_pkg::GROUP_W-1:0]                        acc;
    logic [ipv6p_pkg::DIG_W-1:0]                          dc;
    logic                                                 prev_colon;
    logic                                                 err;
  } pstate_t;

  pstate_t st_r, st_nxt, take_s, fin_s;
  logic [ipv6p_pkg::ADDR_W-1:0] head_flat;

  function automatic pstate_t commit_group(input pstate_t s);
    pstate_t o;
    o = s;
    if (s.dc != '0 && s.gc < ipv6p_pkg::GROUPS_FULL) begin
      if (s.split) begin
        o.tail = {s.tail[ipv6p_pkg::ADDR_W-ipv6p_pkg::GROUP_W-1:0], s.acc};
      end else begin
        o.head[s.gc[2:0]] = s.acc;
      end
      o.gc = s.gc + 4'd1;
    end
    o.acc = '0;
    o.dc  = '0;
    return o;
  endfunction

  always_comb begin
    take_s = st_r;
    if (st_r.gc < ipv6p_pkg::GROUPS_FULL) begin
      if (cls.is_colon) begin
        if (st_r.prev_colon && !st_r.split) begin
          take_s.split = 1'b1;
        end else begin
          take_s = commit_group(st_r);
        end
        take_s.prev_colon = 1'b1;
      end else begin
        take_s.prev_colon = 1'b0;
        if (!cls.is_hex || st_r.dc >= ipv6p_pkg::MAX_DIGITS) begin
          take_s.err = 1'b1;
        end else begin
          take_s.acc = {st_r.acc[ipv6p_pkg::GROUP_W-5:0], cls.nibble};
          take_s.dc  = st_r.dc + 3'd1;
        end
      end
    end
    fin_s = commit_group(take_s);
  end

  // Group 0 goes to the top of the address.
  always_comb begin
    for (int i = 0; i < ipv6p_pkg::GROUPS; i++) begin
      head_flat[ipv6p_pkg::ADDR_W-1-ipv6p_pkg::GROUP_W*i -: ipv6p_pkg::GROUP_W] = fin_s.head[i];
    end
    res.ok   = !fin_s.err;
    res.addr = fin_s.err ? '0 : (head_flat | fin_s.tail);
  end

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      st_nxt = last ? '0 : take_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_gc_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.gc <= ipv6p_pkg::GROUPS_FULL)
    else $error("group count beyond store size");

  a_dc_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.dc <= ipv6p_pkg::MAX_DIGITS)
    else $error("digit count beyond group width");

  a_tail_after_split: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.split |-> st_r.tail == '0)
    else $error("tail groups present without a split");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> st_r.gc == '0 && !st_r.err && !st_r.split)
    else $error("state not cleared after final character");

endmodule

// ----- sv/ipv6p_out_buf.sv -----
// Output stage: holds one address and sends it as high then low word.
`timescale 1ns / 1ps

module ipv6p_out_buf (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  ipv6p_pkg::result_t                 res,
  output logic                               can_load,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [71:0]                        out_tdata,
  output logic                               out_tlast
);

  logic                              vld_r, vld_nxt;
  logic                              phase_r, phase_nxt;
  logic                              ok_r;
  logic [ipv6p_pkg::HALF_W-1:0]      hi_r, lo_r;
  logic [ipv6p_pkg::HALF_W-1:0]      word;

  assign can_load   = !vld_r || (out_tready && phase_r);
  assign word       = phase_r ? lo_r : hi_r;
  assign out_tvalid = vld_r;
  assign out_tdata  = {7'd0, ok_r, word};
  assign out_tlast  = phase_r;

  always_comb begin
    vld_nxt   = vld_r;
    phase_nxt = phase_r;
    if (load) begin
      vld_nxt   = 1'b1;
      phase_nxt = 1'b0;
    end else if (vld_r && out_tready) begin
      if (phase_r) begin
        vld_nxt   = 1'b0;
        phase_nxt = 1'b0;
      end else begin
        phase_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_r <= res.ok;
      hi_r <= res.addr[ipv6p_pkg::ADDR_W-1:ipv6p_pkg::HALF_W];
      lo_r <= res.addr[ipv6p_pkg::HALF_W-1:0];
    end
  end

  a_phase_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> vld_r)
    else $error("low word phase with empty buffer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result loaded over a pending word");

  a_hi_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !phase_r && out_tready && !load |=> vld_r && phase_r)
    else $error("low word did not follow high word");

endmodule

// ----- dv/tb_ipv6_text_address_parser.sv -----
// Testbench for ipv6_text_address_parser: address text in, predicted 64-bit halves checked out.
`timescale 1ns / 1ps

module tb_ipv6_text_address_parser;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_CHARS   = 460;
  localparam int LONG_HOLD     = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int MAX_REPORTS   = 10;

  // One character item on the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  // One expected half of an address on the output channel.
  typedef struct packed {
    logic [ipv6p_pkg::HALF_W-1:0] word;
    logic                         ok;
    logic                         fin;
  } addr_half_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tlast = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [63:0] addr_word, [64] parse_ok, [71:65] zero
  logic        out_tlast;       // word_last

  ipv6_text_address_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Characters waiting to be offered, and address halves still owed by the block.
  text_char_t text_q[$];
  addr_half_t halves_due[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_chars     = 0;
  int mismatches     = 0;
  int cycles         = 0;
  int hold_left      = 0;
  logic hold_req     = 1'b0;
  logic in_taken     = 1'b0;

  // Shadow copy of the parser state.
  logic [ipv6p_pkg::GROUP_W-1:0] kept_groups[ipv6p_pkg::GROUPS];
  logic [ipv6p_pkg::CNT_W-1:0]   n_groups       = '0;
  logic                          gap_seen       = 1'b0;
  logic [ipv6p_pkg::CNT_W-1:0]   gap_at         = '0;
  logic [ipv6p_pkg::GROUP_W-1:0] open_group     = '0;
  logic [ipv6p_pkg::DIG_W-1:0]   open_digits    = '0;
  logic                          last_was_colon = 1'b0;
  logic                          bad_text       = 1'b0;

  initial begin
    foreach (kept_groups[i]) kept_groups[i] = '0;
  end

  // Decode a hex digit: bit 4 flags a valid digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= ipv6p_pkg::CHAR_0 && c <= ipv6p_pkg::CHAR_9)
      return {1'b1, 4'(c - ipv6p_pkg::CHAR_0)};
    if (c >= ipv6p_pkg::CHAR_LO_A && c <= ipv6p_pkg::CHAR_LO_F) begin
      v = c - ipv6p_pkg::CHAR_LO_A + 8'd10;
      return {1'b1, v[3:0]};
    end
    if (c >= ipv6p_pkg::CHAR_UP_A && c <= ipv6p_pkg::CHAR_UP_F) begin
      v = c - ipv6p_pkg::CHAR_UP_A + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'd0;
  endfunction

  // Commit the open group if it holds digits and there is room for it.
  task automatic close_group();
    if (open_digits != 0 && n_groups < ipv6p_pkg::GROUPS) begin
      kept_groups[n_groups[2:0]] = open_group;
      n_groups = n_groups + 1'b1;
    end
    open_group  = '0;
    open_digits = '0;
  endtask

  // Advance the shadow parser by one character; on the final one, owe two halves.
  task automatic parse_char(input logic [7:0] c, input logic fin);
    logic [4:0]                    hx;
    logic [ipv6p_pkg::GROUP_W-1:0] full[ipv6p_pkg::GROUPS];
    logic [ipv6p_pkg::HALF_W-1:0]  hi, lo;
    int                            sp, tail;
    if (n_groups < ipv6p_pkg::GROUPS) begin
      if (c == ipv6p_pkg::CHAR_COLON) begin
        // First "::" marks the gap; any other colon closes the open group.
        if (last_was_colon && !gap_seen) begin
          gap_seen = 1'b1;
          gap_at   = n_groups;
        end else begin
          close_group();
        end
        last_was_colon = 1'b1;
      end else begin
        last_was_colon = 1'b0;
        hx = hex_digit(c);
        if (!hx[4] || open_digits >= ipv6p_pkg::MAX_DIGITS) begin
          bad_text = 1'b1;
        end else begin
          open_group  = {open_group[ipv6p_pkg::GROUP_W-5:0], hx[3:0]};
          open_digits = open_digits + 1'b1;
        end
      end
    end
    if (fin) begin
      close_group();
      sp = gap_seen ? int'(gap_at) : int'(n_groups);
      if (sp > int'(n_groups)) sp = int'(n_groups);
      tail = int'(n_groups) - sp;
      foreach (full[i]) full[i] = '0;
      for (int i = 0; i < sp; i++) full[3'(i)] = kept_groups[3'(i)];
      for (int i = 0; i < tail; i++)
        full[3'(int'(ipv6p_pkg::GROUPS) - tail + i)] = kept_groups[3'(sp + i)];
      hi = {full[0], full[1], full[2], full[3]};
      lo = {full[4], full[5], full[6], full[7]};
      if (bad_text) begin
        hi = '0;
        lo = '0;
      end
      halves_due.push_back('{word: hi, ok: !bad_text, fin: 1'b0});
      halves_due.push_back('{word: lo, ok: !bad_text, fin: 1'b1});
      // Start over for the next address.
      foreach (kept_groups[i]) kept_groups[i] = '0;
      n_groups       = '0;
      gap_seen       = 1'b0;
      gap_at         = '0;
      open_group     = '0;
      open_digits    = '0;
      last_was_colon = 1'b0;
      bad_text       = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [ipv6p_pkg::HALF_W-1:0] want,
                               input logic [ipv6p_pkg::HALF_W-1:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
  endtask

  task automatic queue_char(input logic [7:0] c, input logic fin);
    text_q.push_back('{ch: c, fin: fin});
    sent_chars++;
  endtask

  // Queue a string as one address, tlast on its final character.
  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int k;
    k = $urandom_range(21);
    if (k < 10) return ipv6p_pkg::CHAR_0 + 8'(k);
    if (k < 16) return ipv6p_pkg::CHAR_LO_A + 8'(k - 10);
    return ipv6p_pkg::CHAR_UP_A + 8'(k - 16);
  endfunction

  // Build one random address: mostly well formed with random groups and gap,
  // sometimes with a stray colon, a stray byte or an overlong group, and now
  // and then plain byte noise.
  task automatic queue_address();
    logic [7:0] txt[$];
    int n_grp, gap_pos, nd;
    bit use_gap;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(2))
          0: txt.push_back(ipv6p_pkg::CHAR_COLON);
          1: txt.push_back(rand_hex_char());
          default: txt.push_back(8'($urandom_range(255)));
        endcase
      end
    end else begin
      n_grp   = ($urandom_range(99) < 15) ? 9 : $urandom_range(8);
      use_gap = $urandom_range(99) < 50;
      gap_pos = $urandom_range(n_grp);
      for (int g = 0; g < n_grp; g++) begin
        if (use_gap && g == gap_pos) begin
          txt.push_back(ipv6p_pkg::CHAR_COLON);
          txt.push_back(ipv6p_pkg::CHAR_COLON);
        end else if (g > 0) begin
          txt.push_back(ipv6p_pkg::CHAR_COLON);
        end
        nd = ($urandom_range(99) < 4) ? 5 : $urandom_range(1, 4);
        repeat (nd) txt.push_back(rand_hex_char());
      end
      if (use_gap && gap_pos == n_grp) begin
        txt.push_back(ipv6p_pkg::CHAR_COLON);
        txt.push_back(ipv6p_pkg::CHAR_COLON);
      end
      if (txt.size() == 0) txt.push_back(rand_hex_char());
      if ($urandom_range(99) < 8)
        txt.insert($urandom_range(txt.size()), ipv6p_pkg::CHAR_COLON);
      if ($urandom_range(99) < 6)
        txt.insert($urandom_range(txt.size()), 8'($urandom_range(255)));
    end
    foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1);
  endtask

  // Driver: hold an offered item until it is taken, then offer the next one
  // unless the sender idles this cycle.
  always @(negedge clk) begin
    text_char_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.ch;
        in_tlast  <= nxt.fin;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, counted here so the sender keeps pushing.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall at random, and not at all during a long hold-off.
  always @(negedge clk) begin
    out_tready <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // Monitor: check each taken output item, then predict from each taken input item.
  always @(posedge clk) begin
    addr_half_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (halves_due.size() == 0) begin
          flag_mismatch("unexpected output item", '0, out_tdata[ipv6p_pkg::HALF_W-1:0]);
        end else begin
          want = halves_due.pop_front();
          if (out_tdata[ipv6p_pkg::HALF_W-1:0] !== want.word)
            flag_mismatch("addr_word", want.word, out_tdata[ipv6p_pkg::HALF_W-1:0]);
          if (out_tdata[ipv6p_pkg::HALF_W] !== want.ok)
            flag_mismatch("parse_ok", ipv6p_pkg::HALF_W'(want.ok),
                          ipv6p_pkg::HALF_W'(out_tdata[ipv6p_pkg::HALF_W]));
          if (out_tlast !== want.fin)
            flag_mismatch("word_last", ipv6p_pkg::HALF_W'(want.fin),
                          ipv6p_pkg::HALF_W'(out_tlast));
        end
      end
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tlast);
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      cycles <= cycles + 1;
    end
  end

  initial begin
    int start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed addresses: bare gap, full group with gap, fifth digit, bad
    // character, extreme byte codes, and a second "::" used as a separator.
    queue_text("::");
    queue_text("ffff::A");
    queue_text("12345");
    queue_text("g");
    queue_char(8'hFF, 1'b1);
    queue_char(8'h00, 1'b1);
    queue_text("1::2::3");
    while (text_q.size() != 0 || in_tvalid) @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      start = sent_chars;
      while (sent_chars - start < PHASE_CHARS) queue_address();
      if (ph == 0) begin
        // Block the output while the input keeps coming, so the block backs up.
        @(negedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        hold_req = 1'b0;
      end
      while (text_q.size() != 0 || in_tvalid) @(posedge clk);
    end

    while (halves_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
